// ----- src/subband_nearest_code_quantizer_defines.svh -----
// Assertion macros for the subband quantizer RTL.
// Used by subband_nearest_code_quantizer.sv; relies on clk_i and rst_ni in scope.
`ifndef SUBBAND_NEAREST_CODE_QUANTIZER_DEFINES_SVH
`define SUBBAND_NEAREST_CODE_QUANTIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define SBQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SBQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SBQ_ASSERT_IMP(lbl, ante, cons)
`define SBQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- src/sbq_pkg.sv -----
// Shared types, widths and helpers of the subband quantizer.
// No dependencies.
package sbq_pkg;
  localparam int DVD_W  = 34;
  localparam int STEP_W = 32;
  localparam int LVL_W  = 33;
  localparam int CODE_W = 16;
  localparam int CNT_W  = 17;
  localparam int SB_W   = 5;
  localparam int NCAND  = 5;
  localparam int IDX_W  = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_CODE_COUNT   = 3'd0,
    REG_MIN_LEVEL    = 3'd1,
    REG_MAX_LEVEL    = 3'd2,
    REG_STEP_SIZE    = 3'd3,
    REG_SAMPLE_BITS  = 3'd4,
    REG_RECON_OFFSET = 3'd5,
    REG_RECON_GAIN   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [LVL_W-1:0] sample;
    logic                    forced;
    logic [CODE_W-1:0]       fcode;
  } side_t;

  typedef struct packed {
    logic              ok;
    logic [CODE_W-1:0] code;
    logic [63:0]       gap;
  } cand_t;

  // a holds the lower code, so it wins ties
  function automatic cand_t pick(cand_t a, cand_t b);
    cand_t r;
    if (!b.ok) r = a;
    else if (!a.ok) r = b;
    else if (b.gap < a.gap) r = b;
    else r = a;
    return r;
  endfunction
endpackage

// ----- src/sbq_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on sbq_pkg.
module sbq_div import sbq_pkg::*; (
  input  logic              clk_i,
  input  logic [DVD_W-1:0]  en_i,
  input  logic [DVD_W-1:0]  dvd_i,
  input  logic [STEP_W-1:0] dsr_i,
  input  side_t             side_i,
  output logic [DVD_W-1:0]  quo_o,
  output side_t             side_o
);
  logic [DVD_W-1:0]  dvd_q [DVD_W];
  logic [DVD_W-1:0]  quo_q [DVD_W];
  logic [STEP_W-1:0] rem_q [DVD_W];
  side_t             side_q [DVD_W];

  logic [DVD_W-1:0]  dvd_in [DVD_W];
  logic [DVD_W-1:0]  quo_in [DVD_W];
  logic [STEP_W-1:0] rem_in [DVD_W];
  side_t             side_in [DVD_W];
  logic [STEP_W:0]   trial [DVD_W];
  logic [STEP_W:0]   diff [DVD_W];

  always_comb begin
    for (int j = 0; j < DVD_W; j++) begin
      if (j == 0) begin
        dvd_in[j]  = dvd_i;
        quo_in[j]  = '0;
        rem_in[j]  = '0;
        side_in[j] = side_i;
      end else begin
        dvd_in[j]  = dvd_q[j-1];
        quo_in[j]  = quo_q[j-1];
        rem_in[j]  = rem_q[j-1];
        side_in[j] = side_q[j-1];
      end
      trial[j] = {rem_in[j], dvd_in[j][DVD_W-1]};
      diff[j]  = trial[j] - {1'b0, dsr_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DVD_W; j++) begin
      if (en_i[j]) begin
        dvd_q[j]  <= {dvd_in[j][DVD_W-2:0], 1'b0};
        side_q[j] <= side_in[j];
        if (trial[j] >= {1'b0, dsr_i}) begin
          rem_q[j] <= diff[j][STEP_W-1:0];
          quo_q[j] <= {quo_in[j][DVD_W-2:0], 1'b1};
        end else begin
          rem_q[j] <= trial[j][STEP_W-1:0];
          quo_q[j] <= {quo_in[j][DVD_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_o  = quo_q[DVD_W-1];
  assign side_o = side_q[DVD_W-1];
endmodule

// ----- src/subband_nearest_code_quantizer.sv -----
// Top level of the subband nearest-code quantizer.
// Depends on sbq_pkg, sbq_div and subband_nearest_code_quantizer_defines.svh.
//
// Usage:
//  - Input channel: sample_in_i with in_valid_i / in_ready_o; a transfer
//    takes place on a clock edge with both high.
//  - Output channel: code_out_o with out_valid_o / out_ready_i.
//  - Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//    (code count, min level, max level, step, sample bits, offset, gain).
//    Write only while no sample is in flight.
//  - Pipeline: from input transfer to result valid, a sample passes 42
//    register stages. One stage latches the sample, 34 stages form the
//    divider (one quotient bit each), six stages rebuild, multiply, measure
//    and compare the five candidates, and the last is the output register.
//  - Throughput: one sample per cycle while the receiver does not stall.
//  - Reset clears all valid bits and loads the register defaults.
//  - When the receiver stalls, bubbles close up first; in_ready_o drops only
//    when every stage holds a sample. Nothing is lost or repeated.
`include "subband_nearest_code_quantizer_defines.svh"
module subband_nearest_code_quantizer import sbq_pkg::*; #(
  parameter int FRAC_BITS = 28
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        cfg_idx_i,
  input  logic [LVL_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [LVL_W-1:0] sample_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [CODE_W-1:0]       code_out_o
);
  localparam int NST   = DVD_W + 8;
  localparam int S_C1  = DVD_W + 1;
  localparam int S_C2  = DVD_W + 2;
  localparam int S_C3  = DVD_W + 3;
  localparam int S_C4  = DVD_W + 4;
  localparam int S_C5  = DVD_W + 5;
  localparam int S_C6  = DVD_W + 6;
  localparam int S_OUT = DVD_W + 7;

  logic [CNT_W-1:0]        code_count_q;
  logic signed [LVL_W-1:0] min_level_q, max_level_q;
  logic [STEP_W-1:0]       step_size_q;
  logic [SB_W-1:0]         sample_bits_q;
  logic signed [31:0]      recon_offset_q, recon_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_count_q   <= '0;
      min_level_q    <= '0;
      max_level_q    <= '0;
      step_size_q    <= STEP_W'(1);
      sample_bits_q  <= SB_W'(2);
      recon_offset_q <= '0;
      recon_gain_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CODE_COUNT:   code_count_q   <= cfg_wdata_i[CNT_W-1:0];
        REG_MIN_LEVEL:    min_level_q    <= cfg_wdata_i;
        REG_MAX_LEVEL:    max_level_q    <= cfg_wdata_i;
        REG_STEP_SIZE:    step_size_q    <= cfg_wdata_i[STEP_W-1:0];
        REG_SAMPLE_BITS:  sample_bits_q  <= cfg_wdata_i[SB_W-1:0];
        REG_RECON_OFFSET: recon_offset_q <= cfg_wdata_i[31:0];
        REG_RECON_GAIN:   recon_gain_q   <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  // derived configuration
  logic [CNT_W-1:0]  cc_cl, last;
  logic [STEP_W-1:0] step_e;
  logic [3:0]        tbit;
  always_comb begin
    cc_cl  = (code_count_q > CNT_W'(65536)) ? CNT_W'(65536) : code_count_q;
    last   = cc_cl - CNT_W'(1);
    step_e = (step_size_q == '0) ? STEP_W'(1) : step_size_q;
    if (sample_bits_q < SB_W'(2)) tbit = 4'd1;
    else if (sample_bits_q > SB_W'(16)) tbit = 4'd15;
    else tbit = 4'(sample_bits_q - SB_W'(1));
  end

  // stage advance chain
  logic [NST-1:0] v_q, adv;
  always_comb begin
    adv[NST-1] = !v_q[NST-1] || out_ready_i;
    for (int i = NST - 2; i >= 0; i--) adv[i] = !v_q[i] || adv[i+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (adv[i]) v_q[i] <= (i == 0) ? in_valid_i : v_q[i-1];
      end
    end
  end
  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[S_OUT];

  // input stage
  side_t            p0_side_d, p0_side_q;
  logic [DVD_W-1:0] p0_dvd_d, p0_dvd_q;
  logic             few, at_lo, at_hi;
  always_comb begin
    few   = cc_cl <= CNT_W'(1);
    at_lo = sample_in_i <= min_level_q;
    at_hi = sample_in_i >= max_level_q;
    p0_side_d.sample = sample_in_i;
    p0_side_d.forced = few || at_lo || at_hi;
    p0_side_d.fcode  = (few || at_lo) ? '0 : last[CODE_W-1:0];
    p0_dvd_d = {sample_in_i[LVL_W-1], sample_in_i} - {min_level_q[LVL_W-1], min_level_q}
               + {3'b0, step_e[STEP_W-1:1]};
  end
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      p0_side_q <= p0_side_d;
      p0_dvd_q  <= p0_dvd_d;
    end
  end

  logic [DVD_W-1:0] quo;
  side_t            div_side;
  sbq_div u_div (
    .clk_i  (clk_i),
    .en_i   (adv[DVD_W:1]),
    .dvd_i  (p0_dvd_q),
    .dsr_i  (step_e),
    .side_i (p0_side_q),
    .quo_o  (quo),
    .side_o (div_side)
  );

  function automatic logic [63:0] rebuild(logic [CODE_W-1:0] code, logic [3:0] t,
                                          logic signed [31:0] off);
    logic [63:0] top;
    logic [63:0] r;
    top = 64'd1 << t;
    r = {48'b0, code} ^ top;
    if ((r & top) != 64'd0) r = r | ~(top - 64'd1);
    r = r << (FRAC_BITS - int'(t));
    r = r + {{32{off[31]}}, off};
    return r;
  endfunction

  // C1: estimate clamp, candidate codes and pre-gain values
  logic [CODE_W-1:0] approx;
  logic [CNT_W-1:0]  cstart, cend, cidx [NCAND];
  logic [CODE_W-1:0] c1_code_q [NCAND];
  logic [NCAND-1:0]  c1_ok_q;
  logic [63:0]       c1_r_q [NCAND];
  side_t             c1_side_q;
  always_comb begin
    approx = (quo > {{(DVD_W-CNT_W){1'b0}}, last}) ? last[CODE_W-1:0] : quo[CODE_W-1:0];
    cstart = (approx >= CODE_W'(2)) ? {1'b0, approx} - CNT_W'(2) : '0;
    cend   = ({1'b0, approx} + CNT_W'(2) > last) ? last : {1'b0, approx} + CNT_W'(2);
    for (int i = 0; i < NCAND; i++) cidx[i] = cstart + CNT_W'(i);
  end
  always_ff @(posedge clk_i) begin
    if (adv[S_C1]) begin
      c1_side_q <= div_side;
      for (int i = 0; i < NCAND; i++) begin
        c1_code_q[i] <= cidx[i][CODE_W-1:0];
        c1_ok_q[i]   <= cidx[i] <= cend;
        c1_r_q[i]    <= rebuild(cidx[i][CODE_W-1:0], tbit, recon_offset_q);
      end
    end
  end

  // C2: partial products of the 64-bit wrapping multiply
  logic [63:0]       c2_pl_q [NCAND];
  logic [31:0]       c2_ph_q [NCAND], c2_nl_q [NCAND];
  logic [CODE_W-1:0] c2_code_q [NCAND];
  logic [NCAND-1:0]  c2_ok_q;
  side_t             c2_side_q;
  always_ff @(posedge clk_i) begin
    if (adv[S_C2]) begin
      c2_side_q <= c1_side_q;
      c2_ok_q   <= c1_ok_q;
      for (int i = 0; i < NCAND; i++) begin
        c2_code_q[i] <= c1_code_q[i];
        c2_pl_q[i]   <= {32'b0, c1_r_q[i][31:0]} * {32'b0, recon_gain_q};
        c2_ph_q[i]   <= c1_r_q[i][63:32] * recon_gain_q;
        c2_nl_q[i]   <= recon_gain_q[31] ? 32'd0 - c1_r_q[i][31:0] : 32'd0;
      end
    end
  end

  // C3: product sum
  logic [63:0]       c3_p_q [NCAND];
  logic [CODE_W-1:0] c3_code_q [NCAND];
  logic [NCAND-1:0]  c3_ok_q;
  side_t             c3_side_q;
  always_ff @(posedge clk_i) begin
    if (adv[S_C3]) begin
      c3_side_q <= c2_side_q;
      c3_ok_q   <= c2_ok_q;
      for (int i = 0; i < NCAND; i++) begin
        c3_code_q[i] <= c2_code_q[i];
        c3_p_q[i]    <= c2_pl_q[i] + {c2_ph_q[i] + c2_nl_q[i], 32'b0};
      end
    end
  end

  // C4: reconstruction and distance
  logic signed [63:0] rec [NCAND];
  logic signed [63:0] sx;
  cand_t              c4_q [NCAND];
  side_t              c4_side_q;
  always_comb begin
    sx = {{(64-LVL_W){c3_side_q.sample[LVL_W-1]}}, c3_side_q.sample};
    for (int i = 0; i < NCAND; i++) rec[i] = $signed(c3_p_q[i]) >>> FRAC_BITS;
  end
  always_ff @(posedge clk_i) begin
    if (adv[S_C4]) begin
      c4_side_q <= c3_side_q;
      for (int i = 0; i < NCAND; i++) begin
        c4_q[i].ok   <= c3_ok_q[i];
        c4_q[i].code <= c3_code_q[i];
        c4_q[i].gap  <= (rec[i] >= sx) ? 64'(rec[i] - sx) : 64'(sx - rec[i]);
      end
    end
  end

  // C5, C6: compare tree
  cand_t c5_w01_q, c5_w23_q, c5_w4_q, c6_w03_q, c6_w4_q;
  side_t c5_side_q, c6_side_q;
  always_ff @(posedge clk_i) begin
    if (adv[S_C5]) begin
      c5_side_q <= c4_side_q;
      c5_w01_q  <= pick(c4_q[0], c4_q[1]);
      c5_w23_q  <= pick(c4_q[2], c4_q[3]);
      c5_w4_q   <= c4_q[4];
    end
    if (adv[S_C6]) begin
      c6_side_q <= c5_side_q;
      c6_w03_q  <= pick(c5_w01_q, c5_w23_q);
      c6_w4_q   <= c5_w4_q;
    end
  end

  cand_t             win;
  logic [CODE_W-1:0] code_q;
  assign win = pick(c6_w03_q, c6_w4_q);
  always_ff @(posedge clk_i) begin
    if (adv[S_OUT]) code_q <= c6_side_q.forced ? c6_side_q.fcode : win.code;
  end
  assign code_out_o = code_q;

  `SBQ_ASSERT_IMP(a_stall_from_out, !in_ready_o, out_valid_o && !out_ready_i)
  `SBQ_ASSERT_IMP(a_first_cand_ok, v_q[S_C2], c2_ok_q[0])
  `SBQ_ASSERT_NXT(a_item_moves, v_q[S_C6] && adv[S_OUT], v_q[S_OUT])
endmodule

// ----- tb/sv/subband_nearest_code_quantizer_test.sv -----
// Testbench for subband_nearest_code_quantizer: directed and random samples under
// several register settings, with code predictions checked in order by a scoreboard.
// Depends on sbq_pkg and the quantizer RTL.
`timescale 1ns / 1ps
module subband_nearest_code_quantizer_test;
  import sbq_pkg::*;

  localparam int FRAC = 28;
  localparam int LIMIT = 400000;

  typedef enum int {
    CHK_OK,
    CHK_EMPTY,
    CHK_WRONG
  } check_e;

  class code_scoreboard;
    logic [CODE_W-1:0] pending_codes[$];
    int errors;
    int checked;

    function void note_code(logic [CODE_W-1:0] c);
      pending_codes.insert(pending_codes.size(), c);
    endfunction

    function check_e check_code(logic [CODE_W-1:0] got);
      logic [CODE_W-1:0] want;
      if (pending_codes.size() == 0) begin
        return CHK_EMPTY;
      end
      want = pending_codes.pop_front();
      checked++;
      if (got !== want) return CHK_WRONG;
      return CHK_OK;
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [IDX_W-1:0] cfg_idx_i = '0;
  logic [LVL_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic signed [LVL_W-1:0] sample_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic [CODE_W-1:0] code_out_o;

  int send_idle, recv_idle, cycles, mismatches, sent;
  code_scoreboard codes;

  logic [16:0] code_count_q;
  logic signed [32:0] min_level_q, max_level_q;
  logic [31:0] step_q;
  logic [4:0] sbits_q;
  logic signed [31:0] offset_q, gain_q;

  subband_nearest_code_quantizer dut (.*);

  always #5 clk_i = ~clk_i;

  task automatic report(string what);
    $display("mismatch @%0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic signed [63:0] rebuild_level(logic [31:0] k);
    int s;
    logic [63:0] top, r, p;
    s = (sbits_q < 2) ? 2 : (sbits_q > 16) ? 16 : sbits_q;
    top = 64'd1 << (s - 1);
    r = {32'd0, k} ^ top;
    if ((r & top) != 0) r = r | ~(top - 64'd1);
    r = r << (FRAC - (s - 1));
    r = r + {{32{offset_q[31]}}, offset_q};
    p = r * {{32{gain_q[31]}}, gain_q};
    return $signed(p) >>> FRAC;
  endfunction

  function automatic logic [CODE_W-1:0] nearest_code(logic signed [32:0] smp);
    logic [31:0] cc, last, approx, lo, hi, best;
    logic [63:0] st, q, d, best_d;
    logic signed [63:0] s64, r;
    cc = code_count_q;
    if (cc > 65536) cc = 65536;
    if (cc <= 1) return '0;
    last = cc - 1;
    if (smp <= min_level_q) return '0;
    if (smp >= max_level_q) return last[CODE_W-1:0];
    st = (step_q == 0) ? 64'd1 : {32'd0, step_q};
    s64 = smp;
    q = (64'(s64 - 64'(min_level_q)) + st / 2) / st;
    approx = (q > last) ? last : q[31:0];
    lo = (approx >= 2) ? approx - 2 : 0;
    hi = (approx + 2 > last) ? last : approx + 2;
    best = approx;
    best_d = '1;
    for (logic [31:0] k = lo; k <= hi; k++) begin
      r = rebuild_level(k);
      d = (r >= s64) ? 64'(r - s64) : 64'(s64 - r);
      if (d < best_d) begin
        best_d = d;
        best = k;
      end
    end
    return best[CODE_W-1:0];
  endfunction

  // leaves cfg_we_i high; setup drops it after the last write
  task automatic write_reg(cfg_reg_e idx, logic [LVL_W-1:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_CODE_COUNT: code_count_q = val[16:0];
      REG_MIN_LEVEL: min_level_q = val;
      REG_MAX_LEVEL: max_level_q = val;
      REG_STEP_SIZE: step_q = val[31:0];
      REG_SAMPLE_BITS: sbits_q = val[4:0];
      REG_RECON_OFFSET: offset_q = val[31:0];
      default: gain_q = val[31:0];
    endcase
  endtask

  task automatic setup(logic [16:0] cc, logic signed [32:0] mn, logic signed [32:0] mx,
                       logic [31:0] st, logic [4:0] sb, logic [31:0] off, logic [31:0] gn);
    write_reg(REG_CODE_COUNT, cc);
    write_reg(REG_MIN_LEVEL, mn);
    write_reg(REG_MAX_LEVEL, mx);
    write_reg(REG_STEP_SIZE, st);
    write_reg(REG_SAMPLE_BITS, sb);
    write_reg(REG_RECON_OFFSET, off);
    write_reg(REG_RECON_GAIN, gn);
    cfg_we_i <= 0;
  endtask

  task automatic send_sample(logic signed [32:0] smp);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    sample_in_i <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    codes.note_code(nearest_code(smp));
    sent++;
  endtask

  task automatic drain;
    in_valid_i <= 0;
    while (codes.pending_codes.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic signed [32:0] pick_sample();
    logic signed [32:0] span;
    case ($urandom_range(3))
      0: return 33'({$urandom_range(1), $urandom});
      1: return min_level_q + $signed({1'b0, $urandom_range(1000)}) - 500;
      default: begin
        span = max_level_q - min_level_q;
        if (span <= 0) return 33'({$urandom_range(1), $urandom});
        return min_level_q + $signed(33'({32'd0, $urandom} % 64'(span)));
      end
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [4:0] sb;
    logic [16:0] cc;
    logic signed [32:0] mn;
    logic [31:0] st;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        drain();
        sb = 5'($urandom_range(31));
        cc = ($urandom_range(9) == 0) ? 17'($urandom) : 17'd1 << ((sb > 16 ? 16 : sb));
        st = ($urandom_range(9) == 0) ? 0 : $urandom_range(1 << 20);
        mn = -$signed({1'b0, 32'($urandom_range(1 << 30))});
        setup(cc, mn, mn + $signed({1'b0, st}) * cc, st, sb,
              $urandom, ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 29));
      end
      send_sample(pick_sample());
    end
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        case (codes.check_code(code_out_o))
          CHK_EMPTY: report($sformatf("unexpected code %0d", code_out_o));
          CHK_WRONG: report($sformatf("code %0d wrong", code_out_o));
          default: ;
        endcase
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    codes = new();
    code_count_q = 0; min_level_q = 0; max_level_q = 0; step_q = 1;
    sbits_q = 2; offset_q = 0; gain_q = 0;
    send_idle = 33; recv_idle = 82;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_sample(33'sd5);
    drain();
    setup(17'd1, 0, 100, 1, 2, 0, 0);
    send_sample(33'sd50);
    drain();
    setup(17'd16, -33'sd1000, 33'sd1000, 125, 4, 32'sd0, 32'sd1 <<< 28);
    send_sample(-33'sd1000); send_sample(-33'sd1001); send_sample(33'sd1000);
    send_sample(33'sd999); send_sample(33'sd0); send_sample(33'sd62);
    send_sample(33'sd63); send_sample(33'h0FFFFFFFF); send_sample(33'h100000000);
    drain();
    setup(17'h1FFFF, 33'h100000000, 33'h0FFFFFFFF, 0, 31, 32'h80000000, 32'h7FFFFFFF);
    send_sample(33'h100000001); send_sample(33'h0FFFFFFFE); send_sample(33'h100000000);
    drain();
    setup(17'd65536, 33'h100000000, 33'h0FFFFFFFF, 32'hFFFFFFFF, 0, 32'h7FFFFFFF,
          32'h80000000);
    send_sample(33'sd0); send_sample(33'sd1); send_sample(-33'sd7);
    drain();
    setup(17'd10, 33'sd50, -33'sd50, 10, 16, 0, 32'sd1 <<< 20);
    send_sample(33'sd50); send_sample(33'sd0); send_sample(33'sd60);
    drain();
    random_phase(210);
    send_idle = 82; recv_idle = 33;
    random_phase(210);
    send_idle = 0; recv_idle = 0;
    random_phase(210);
    drain();
    $display("sent %0d samples across many register settings, %0d codes checked",
             sent, codes.checked);
    if (mismatches == 0 && codes.pending_codes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
